FILE: design/tksd_pkg.sv
package tksd_pkg;

	localparam int unsigned MAX_SEQUENCE_DEF = 7;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic [7:0] IDX_UNKNOWN = 8'd255;
	localparam logic [7:0] IDX_ESCAPE = 8'd228;
	localparam logic [7:0] BYTE_ESC = 8'd27;
	localparam logic [7:0] BYTE_LBRACKET = 8'd91;
	localparam logic [7:0] BYTE_TILDE = 8'd126;
	localparam logic [7:0] BYTE_SEMI = 8'd59;
	localparam logic [7:0] BYTE_ONE = 8'd49;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_ESC_WAIT = 2'd1,
		MODE_ESC_SEQ = 2'd2,
		MODE_UTF8    = 2'd3
	} mode_t;

	// request passed from the front part to the back part
	typedef struct packed {
		logic       is_tick;
		logic [7:0] data_byte;
	} req_t;

	// key class from table index
	function automatic logic [3:0] class_of(input logic [7:0] idx);
		logic [7:0] b;
		begin
			b = idx + 8'd1;
			if (idx == 8'd9) class_of = 4'd1;
			else if (idx == 8'd10) class_of = 4'd2;
			else if (idx == 8'd13) class_of = 4'd3;
			else if (idx <= 8'd30) class_of = 4'd0;
			else if (idx <= 8'd126) begin
				if (b >= 8'd48 && b <= 8'd57) class_of = 4'd5;
				else if (b >= 8'd65 && b <= 8'd90) class_of = 4'd6;
				else if (b >= 8'd97 && b <= 8'd122) class_of = 4'd7;
				else if (b == 8'd127) class_of = 4'd8;
				else class_of = 4'd4;
			end
			else if (idx <= 8'd181) class_of = 4'd9;
			else if (idx <= 8'd227) class_of = 4'd10;
			else if (idx == 8'd228) class_of = 4'd11;
			else if (idx <= 8'd236) class_of = 4'd12;
			else if (idx == 8'd237) class_of = 4'd13;
			else if (idx <= 8'd244) class_of = 4'd14;
			else class_of = 4'd15;
		end
	endfunction

	// multi-byte character lookup; c is 0 for two-byte characters
	function automatic logic [7:0] mb_lookup(input logic three, input logic [7:0] a,
			input logic [7:0] b, input logic [7:0] c);
		logic [23:0] k;
		begin
			k = {a, b, c};
			mb_lookup = IDX_UNKNOWN;
			if (!three) begin
				unique case (k)
					24'hC2BA00: mb_lookup = 8'd127; 24'hC2A100: mb_lookup = 8'd128;
					24'hC2A300: mb_lookup = 8'd130; 24'hC2A200: mb_lookup = 8'd131;
					24'hC2A700: mb_lookup = 8'd133; 24'hC2B600: mb_lookup = 8'd134;
					24'hC2AA00: mb_lookup = 8'd136; 24'hC3A500: mb_lookup = 8'd137;
					24'hC3A700: mb_lookup = 8'd139; 24'hC69200: mb_lookup = 8'd141;
					24'hC2A900: mb_lookup = 8'd142; 24'hCB9900: mb_lookup = 8'd143;
					24'hCB9A00: mb_lookup = 8'd145; 24'hC2AC00: mb_lookup = 8'd146;
					24'hC2B500: mb_lookup = 8'd147; 24'hC3B800: mb_lookup = 8'd148;
					24'hCF8000: mb_lookup = 8'd149; 24'hC59300: mb_lookup = 8'd150;
					24'hC2AE00: mb_lookup = 8'd151; 24'hC39F00: mb_lookup = 8'd152;
					24'hC2A500: mb_lookup = 8'd157; 24'hCEA900: mb_lookup = 8'd158;
					24'hC2AB00: mb_lookup = 8'd159; 24'hC3A600: mb_lookup = 8'd160;
					24'hC3B700: mb_lookup = 8'd161;
					24'hC38500: mb_lookup = 8'd182; 24'hC4B100: mb_lookup = 8'd183;
					24'hC38700: mb_lookup = 8'd184; 24'hC38E00: mb_lookup = 8'd185;
					24'hC2B400: mb_lookup = 8'd186; 24'hC38F00: mb_lookup = 8'd187;
					24'hCB9D00: mb_lookup = 8'd188; 24'hC39300: mb_lookup = 8'd189;
					24'hCB8600: mb_lookup = 8'd190; 24'hC39400: mb_lookup = 8'd191;
					24'hC39C00: mb_lookup = 8'd193; 24'hC38200: mb_lookup = 8'd194;
					24'hCB9C00: mb_lookup = 8'd195; 24'hC39800: mb_lookup = 8'd196;
					24'hC59200: mb_lookup = 8'd198; 24'hC38D00: mb_lookup = 8'd200;
					24'hCB8700: mb_lookup = 8'd201; 24'hC2A800: mb_lookup = 8'd202;
					24'hCB9B00: mb_lookup = 8'd205; 24'hC38100: mb_lookup = 8'd206;
					24'hC2B800: mb_lookup = 8'd207; 24'hC27900: mb_lookup = 8'd208;
					24'hC2AF00: mb_lookup = 8'd209; 24'hC2B000: mb_lookup = 8'd210;
					24'hC2B100: mb_lookup = 8'd211; 24'hC2B700: mb_lookup = 8'd212;
					24'hC2BB00: mb_lookup = 8'd213; 24'hC38600: mb_lookup = 8'd214;
					24'hC39A00: mb_lookup = 8'd215; 24'hCB9800: mb_lookup = 8'd216;
					default: mb_lookup = IDX_UNKNOWN;
				endcase
			end else begin
				unique case (k)
					24'hE284A2: mb_lookup = 8'd129; 24'hE2889E: mb_lookup = 8'd132;
					24'hE280A2: mb_lookup = 8'd135; 24'hE288AB: mb_lookup = 8'd138;
					24'hE28882: mb_lookup = 8'd140; 24'hE28886: mb_lookup = 8'd144;
					24'hE280A0: mb_lookup = 8'd153; 24'hE2889A: mb_lookup = 8'd154;
					24'hE28891: mb_lookup = 8'd155; 24'hE28988: mb_lookup = 8'd156;
					24'hE280A6: mb_lookup = 8'd162; 24'hE289A0: mb_lookup = 8'd163;
					24'hE289A4: mb_lookup = 8'd164; 24'hE289A5: mb_lookup = 8'd165;
					24'hE28093: mb_lookup = 8'd166; 24'hE28098: mb_lookup = 8'd167;
					24'hE2809C: mb_lookup = 8'd168; 24'hEFA3BF: mb_lookup = 8'd192;
					24'hE2888F: mb_lookup = 8'd197; 24'hE280B0: mb_lookup = 8'd199;
					24'hE2978A: mb_lookup = 8'd203; 24'hE2809E: mb_lookup = 8'd204;
					24'hE280A1: mb_lookup = 8'd217; 24'hE280B9: mb_lookup = 8'd218;
					24'hE280BA: mb_lookup = 8'd219; 24'hE28184: mb_lookup = 8'd220;
					24'hE282AC: mb_lookup = 8'd221; 24'hEFAC81: mb_lookup = 8'd222;
					24'hEFAC82: mb_lookup = 8'd223; 24'hE28094: mb_lookup = 8'd224;
					24'hE28099: mb_lookup = 8'd225; 24'hE2809A: mb_lookup = 8'd226;
					24'hE2809D: mb_lookup = 8'd227;
					default: mb_lookup = IDX_UNKNOWN;
				endcase
			end
		end
	endfunction

endpackage

FILE: design/tksd_queue.sv
module tksd_queue
	import tksd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  req_t wr_data,
	output logic full,
	input  logic rd_en,
	output req_t rd_data,
	output logic empty
);

	// two-entry queue between the front and back parts
	req_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule

FILE: design/tksd_front.sv
module tksd_front
	import tksd_pkg::*;
(
	input  logic in_valid,
	output logic in_stall,
	input  logic is_tick,
	input  logic [7:0] data_byte,
	input  logic q_full,
	output logic q_wr,
	output req_t q_data
);

	// forward every request; a tick carries no byte
	assign in_stall = q_full;
	assign q_wr     = in_valid && !q_full;
	assign q_data   = '{is_tick: is_tick, data_byte: is_tick ? 8'd0 : data_byte};

endmodule

FILE: design/tksd_back.sv
module tksd_back
	import tksd_pkg::*;
#(
	parameter int unsigned MAX_SEQUENCE = MAX_SEQUENCE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic q_empty,
	input  req_t q_data,
	output logic q_rd,
	output logic out_valid,
	input  logic out_stall,
	output logic [3:0] key_class,
	output logic [7:0] key_index
);

	mode_t       mode_q, mode_d;
	logic [7:0]  held_q [6];
	logic [2:0]  cnt_q, cnt_d;
	logic [15:0] ticks_q, ticks_d;
	logic [15:0] tmo_q;
	logic        ov_q;
	logic [7:0]  idx_q;
	logic        emit;
	logic [7:0]  emit_idx;
	logic        store;
	logic [2:0]  store_at;
	logic [7:0]  b1, b2, b3, b4, b5, by;
	logic [3:0]  n;
	logic        tk;
	logic [15:0] tick_inc;
	logic [15:0] tmo_eff;

	assign q_rd      = !q_empty && (!ov_q || !out_stall);
	assign out_valid = ov_q;
	assign key_index = idx_q;
	assign key_class = class_of(idx_q);

	assign tk = q_data.is_tick;
	assign by = q_data.data_byte;
	assign b1 = held_q[1];
	assign b2 = held_q[2];
	assign b3 = held_q[3];
	assign b4 = held_q[4];
	assign b5 = held_q[5];
	assign n  = {1'b0, cnt_q} + 4'd1;
	assign tick_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
	assign tmo_eff  = (tmo_q == 16'd0) ? 16'd1 : tmo_q;

	always_comb begin
		mode_d   = mode_q;
		cnt_d    = cnt_q;
		ticks_d  = ticks_q;
		emit     = 1'b0;
		emit_idx = IDX_UNKNOWN;
		store    = 1'b0;
		store_at = 3'd0;
		unique case (mode_q)
			MODE_IDLE: begin
				if (!tk) begin
					if (by == BYTE_ESC) begin
						store = 1'b1; cnt_d = 3'd1; ticks_d = 16'd0;
						mode_d = MODE_ESC_WAIT;
					end else if (by < BYTE_ESC) begin
						emit = 1'b1; emit_idx = by;
					end else if (by <= 8'd127) begin
						emit = 1'b1; emit_idx = by - 8'd1;
					end else if ((by >= 8'd194 && by <= 8'd207) || by == 8'd226
							|| by == 8'd239) begin
						store = 1'b1; cnt_d = 3'd1; mode_d = MODE_UTF8;
					end else begin
						emit = 1'b1;
					end
				end
			end
			MODE_ESC_WAIT: begin
				if (tk) begin
					ticks_d = tick_inc;
					if (tick_inc >= tmo_eff) begin
						emit = 1'b1; emit_idx = IDX_ESCAPE;
					end
				end else begin
					store = 1'b1; store_at = 3'd1; cnt_d = 3'd2; mode_d = MODE_ESC_SEQ;
				end
			end
			MODE_ESC_SEQ: begin
				if (!tk) begin
					emit = 1'b1;
					emit_idx = 8'hFF;
					if (n == 4'd3 && b1 == BYTE_LBRACKET && by == 8'd65) emit_idx = 8'd231;
					else if (n == 4'd3 && b1 == BYTE_LBRACKET && by == 8'd66) emit_idx = 8'd232;
					else if (n == 4'd3 && b1 == BYTE_LBRACKET && by == 8'd67) emit_idx = 8'd233;
					else if (n == 4'd3 && b1 == BYTE_LBRACKET && by == 8'd68) emit_idx = 8'd234;
					else if (n == 4'd3 && b1 == BYTE_LBRACKET && by == 8'd70) emit_idx = 8'd235;
					else if (n == 4'd3 && b1 == BYTE_LBRACKET && by == 8'd72) emit_idx = 8'd236;
					else if (n == 4'd4 && b1 == BYTE_LBRACKET && by == BYTE_TILDE
							&& b2 == 8'd51) emit_idx = 8'd177;
					else if (n == 4'd4 && b1 == BYTE_LBRACKET && by == BYTE_TILDE
							&& b2 == 8'd53) emit_idx = 8'd229;
					else if (n == 4'd4 && b1 == BYTE_LBRACKET && by == BYTE_TILDE
							&& b2 == 8'd54) emit_idx = 8'd230;
					else if (n == 4'd4 && b1 == BYTE_ESC && b2 == BYTE_LBRACKET
							&& by >= 8'd65 && by <= 8'd68) emit_idx = 8'd106 + by;
					else if (n == 4'd5 && b1 == BYTE_ESC && b2 == BYTE_LBRACKET
							&& by == BYTE_TILDE && b3 == 8'd53) emit_idx = 8'd169;
					else if (n == 4'd5 && b1 == BYTE_ESC && b2 == BYTE_LBRACKET
							&& by == BYTE_TILDE && b3 == 8'd54) emit_idx = 8'd170;
					else if (n == 4'd5 && !(b1 == BYTE_LBRACKET && b2 == BYTE_ONE))
						emit_idx = IDX_UNKNOWN;
					else if (n == 4'd5 && by == BYTE_TILDE && b3 == 8'd53) emit_idx = 8'd238;
					else if (n == 4'd5 && by == BYTE_TILDE && b3 == 8'd55) emit_idx = 8'd239;
					else if (n == 4'd6 && b3 == BYTE_SEMI && b4 == 8'd50 && by == 8'd80)
						emit_idx = 8'd240;
					else if (n == 4'd6 && b3 == BYTE_SEMI && b4 == 8'd50 && by == 8'd83)
						emit_idx = 8'd241;
					else if (n == 4'd6 && b3 == BYTE_SEMI && b4 == 8'd57 && by == 8'd70)
						emit_idx = 8'd175;
					else if (n == 4'd6 && b3 == BYTE_SEMI && b4 == 8'd57 && by == 8'd72)
						emit_idx = 8'd176;
					else if (n == 4'd6 && b3 == BYTE_SEMI && b4 == 8'd50 && by == 8'd68)
						emit_idx = 8'd237;
					else if (n == 4'd7 && b4 == BYTE_SEMI && b5 == 8'd50
							&& by == BYTE_TILDE && b3 == 8'd53) emit_idx = 8'd242;
					else if (n == 4'd7 && b4 == BYTE_SEMI && b5 == 8'd50
							&& by == BYTE_TILDE && b3 == 8'd55) emit_idx = 8'd243;
					else if (n == 4'd7 && b4 == BYTE_SEMI && b5 == 8'd50
							&& by == BYTE_TILDE && b3 == 8'd56) emit_idx = 8'd244;
					else if ({28'd0, n} >= MAX_SEQUENCE) emit_idx = IDX_UNKNOWN;
					else begin
						// no decision yet: hold the byte and keep reading
						emit = 1'b0;
						store = (n <= 4'd6);
						store_at = cnt_q;
						cnt_d = n[2:0];
					end
				end
			end
			MODE_UTF8: begin
				if (!tk) begin
					if (held_q[0] == 8'd226 || held_q[0] == 8'd239) begin
						if (n < 4'd3) begin
							store = 1'b1; store_at = cnt_q; cnt_d = n[2:0];
						end else begin
							emit = 1'b1;
							emit_idx = mb_lookup(1'b1, held_q[0], b1, by);
						end
					end else begin
						emit = 1'b1;
						emit_idx = mb_lookup(1'b0, held_q[0], by, 8'd0);
					end
				end
			end
			default: ;
		endcase
		if (emit) begin
			mode_d = MODE_IDLE; cnt_d = 3'd0; ticks_d = 16'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd && store) held_q[store_at] <= by;
		if (q_rd && emit) idx_q <= emit_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			cnt_q   <= 3'd0;
			ticks_q <= 16'd0;
			tmo_q   <= TIMEOUT_RESET;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_we) tmo_q <= cfg_wdata;
			if (q_rd) begin
				mode_q  <= mode_d;
				cnt_q   <= cnt_d;
				ticks_q <= ticks_d;
			end
			if (q_rd && emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

endmodule

FILE: design/terminal_key_sequence_decoder_core.sv
// channel   | valid     | stall     | payload
// input     | in_valid  | in_stall  | is_tick, data_byte
// output    | out_valid | out_stall | key_class, key_index
// config    | cfg_we    | (none)    | cfg_wdata
//
// One request per cycle in while in_stall is low, and one key per cycle out while
// out_stall is low. A key is registered at the output once its last byte has been
// read from the queue; requests waiting ahead of it and a stalled held key delay it.
// Reset clears parse state and loads the escape timeout with 100 ticks.
// While a held key is stalled the two-entry queue takes up to two more requests, then
// in_stall rises until the key leaves.
module terminal_key_sequence_decoder_core
	import tksd_pkg::*;
#(
	parameter int unsigned MAX_SEQUENCE = MAX_SEQUENCE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic is_tick,
	input  logic [7:0] data_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic [3:0] key_class,
	output logic [7:0] key_index
);

	logic q_full, q_wr, q_rd, q_empty;
	req_t q_wdata, q_rdata;

	tksd_front u_front (
		.in_valid(in_valid), .in_stall(in_stall),
		.is_tick(is_tick), .data_byte(data_byte), .q_full(q_full), .q_wr(q_wr),
		.q_data(q_wdata)
	);

	tksd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(q_wr), .wr_data(q_wdata), .full(q_full),
		.rd_en(q_rd), .rd_data(q_rdata), .empty(q_empty)
	);

	tksd_back #(.MAX_SEQUENCE(MAX_SEQUENCE)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.q_empty(q_empty), .q_data(q_rdata), .q_rd(q_rd), .out_valid(out_valid),
		.out_stall(out_stall), .key_class(key_class), .key_index(key_index)
	);

`ifndef SYNTHESIS
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> in_stall) else $error("input taken while queue full");
	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> !q_rd) else $error("queue read while empty");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(key_index)))
		else $error("stalled key changed");
`endif

endmodule
